[rtl/scba_pkg.sv]
package scba_pkg;

  localparam int SIZE_W = 13;
  localparam int ADDR_W = 16;
  localparam int WORD_W = 14;
  localparam int LINK_W = 15;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVERSIZE = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_POP_RD,
    S_POP_WAIT,
    S_SPREAD,
    S_DONE
  } state_t;

  // Effective class size: cap at 4096 and round up to 4.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] c;
    logic [SIZE_W:0] r;
    c = (v > 13'd4096) ? 13'd4096 : v;
    r = {1'b0, c} + 14'd3;
    eff_size = r[SIZE_W-1:0] & ~13'd3;
  endfunction

endpackage

[rtl/size_class_block_allocator_unit.sv]
// Size-class block allocator.
// Input channel in_valid/in_ready carries one request beat: in_req_type
// (0 alloc, 1 free), in_req_size and in_block_addr. Output channel
// out_valid/out_ready returns one beat per request: out_status and
// out_result_addr. Class sizes are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce.
// One request at a time: the class scan visits one class per cycle until the
// first unused class or the last one, then a push, carve or failure is
// settled in the decide state, while a pop goes on through the pop read and
// pop wait states for the registered link memory read. A page refill adds a
// spreading walk that hands the rest of the new page, or the old region if
// that is the smaller, round-robin to the class lists.
// Reset empties every class list and clears the region, spill index and
// page count; the link memory is not cleared, since a head is valid only
// after a push that writes its link. The result waits in an output register
// while the receiver stalls, and no new request is taken until it is taken.
module size_class_block_allocator_unit
  import scba_pkg::*;
#(
  parameter int NUM_CLASSES = 8,
  parameter int PAGE_BYTES = 4096,
  parameter int ARENA_PAGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [SIZE_W-1:0] in_req_size,
  input  logic [ADDR_W-1:0] in_block_addr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_result_addr,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PW = $clog2(ARENA_PAGES + 1);
  localparam int DEPTH = 1 << WORD_W;
  localparam logic [17:0] PAGE_L = 18'(PAGE_BYTES);
  localparam logic [CW-1:0] LAST_C = CW'(NUM_CLASSES - 1);

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] csize_r [NUM_CLASSES];
  logic [LINK_W-1:0] head_r [NUM_CLASSES];
  logic [LINK_W-1:0] link_mem [DEPTH];
  logic [LINK_W-1:0] link_q;

  logic [ADDR_W-1:0] region_ptr_r;
  logic [SIZE_W-1:0] region_left_r;
  logic [CW-1:0]     spill_r;
  logic [PW-1:0]     pages_r;

  logic              type_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] baddr_r;
  logic [CW-1:0]     c_r;
  logic [CW-1:0]     k_r;
  logic [CW:0]       n_r;
  logic              found_r;
  logic [ADDR_W-1:0] sp_addr_r;
  logic [17:0]       sp_left_r;
  logic [SIZE_W-1:0] sp_start_r;
  logic [CW-1:0]     sp_i_r;
  logic [1:0]        stat_r;
  logic [ADDR_W-1:0] res_r;
  logic              out_valid_r;

  // Shared compare/subtract unit operand selection
  logic [CW-1:0]     sel_c;
  logic [SIZE_W-1:0] cur_eff;
  logic [SIZE_W-1:0] sp_eff;
  assign sel_c   = (state_r == S_SCAN) ? k_r : c_r;
  assign cur_eff = eff_size(csize_r[sel_c]);
  assign sp_eff  = eff_size(csize_r[sp_i_r]);

  logic              we;
  logic [WORD_W-1:0] waddr;
  logic [LINK_W-1:0] wdata;
  logic [WORD_W-1:0] raddr;

  always_ff @(posedge clk) begin
    if (we) link_mem[waddr] <= wdata;
    link_q <= link_mem[raddr];
  end
  assign raddr = head_r[c_r][WORD_W-1:0];

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = stat_r;
  assign out_result_addr = res_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SCAN;
      S_SCAN: begin
        if (cur_eff == '0 || k_r == LAST_C)
          state_nxt = S_DECIDE;
      end
      S_DECIDE: state_nxt = S_DONE;
      S_POP_RD: state_nxt = S_POP_WAIT;
      S_POP_WAIT: state_nxt = S_DONE;
      S_SPREAD: if (sp_left_r < {5'd0, sp_start_r}) state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_DECIDE && found_r && type_r == REQ_ALLOC) begin
      if (head_r[c_r][LINK_W-1]) state_nxt = S_POP_RD;
      else if (region_left_r < cur_eff && {1'b0, pages_r} < (PW+1)'(ARENA_PAGES)
               && {5'd0, cur_eff} <= PAGE_L)
        state_nxt = S_SPREAD;
    end
  end

  // Push to link memory
  always_comb begin
    we = 1'b0;
    waddr = baddr_r[ADDR_W-1:2];
    wdata = head_r[c_r];
    if (state_r == S_DECIDE && found_r && type_r == REQ_FREE) we = 1'b1;
    if (state_r == S_SPREAD && sp_left_r >= {5'd0, sp_start_r}
        && {5'd0, sp_eff} <= sp_left_r) begin
      we = 1'b1;
      waddr = sp_addr_r[ADDR_W-1:2];
      wdata = head_r[sp_i_r];
    end
  end

  always_ff @(posedge clk) begin
    logic [ADDR_W-1:0] page;
    logic [17:0] rest;
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      region_ptr_r <= '0;
      region_left_r <= '0;
      spill_r <= '0;
      pages_r <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_r[i] <= '0;
        csize_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we && {29'd0, cfg_index} < NUM_CLASSES)
        csize_r[cfg_index[CW-1:0]] <= cfg_data;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid) begin
          type_r <= in_req_type;
          size_r <= in_req_size;
          baddr_r <= in_block_addr;
          c_r <= '0;
          k_r <= '0;
          n_r <= '0;
          found_r <= 1'b0;
        end
        S_SCAN: begin
          // step one class per cycle; count active classes, keep first match
          if (cur_eff != '0) begin
            n_r <= n_r + 1'b1;
            if (!found_r && cur_eff >= size_r) begin
              found_r <= 1'b1;
              c_r <= k_r;
            end
          end
          if (k_r != LAST_C) k_r <= k_r + 1'b1;
        end
        S_DECIDE: begin
          page = ADDR_W'(pages_r * PAGE_BYTES);
          rest = PAGE_L - {5'd0, cur_eff};
          if (!found_r) begin
            stat_r <= ST_OVERSIZE;
            res_r <= '0;
          end else if (type_r == REQ_FREE) begin
            stat_r <= ST_OK;
            res_r <= '0;
            head_r[c_r] <= {1'b1, baddr_r[ADDR_W-1:2]};
          end else if (head_r[c_r][LINK_W-1]) begin
            stat_r <= ST_OK;
            res_r <= {head_r[c_r][WORD_W-1:0], 2'b00};
          end else if (region_left_r >= cur_eff) begin
            stat_r <= ST_OK;
            res_r <= region_ptr_r;
            region_ptr_r <= region_ptr_r + ADDR_W'(cur_eff);
            region_left_r <= region_left_r - cur_eff;
          end else if (state_nxt == S_SPREAD) begin
            stat_r <= ST_OK;
            pages_r <= pages_r + 1'b1;
            res_r <= page;
            if ({5'd0, region_left_r} < rest) begin
              sp_addr_r <= region_ptr_r;
              sp_left_r <= {5'd0, region_left_r};
              region_ptr_r <= page + ADDR_W'(cur_eff);
              region_left_r <= rest[SIZE_W-1:0];
            end else begin
              sp_addr_r <= page + ADDR_W'(cur_eff);
              sp_left_r <= rest;
            end
            if ({1'b0, spill_r} >= n_r) begin
              sp_i_r <= '0;
              sp_start_r <= eff_size(csize_r[0]);
            end else begin
              sp_i_r <= spill_r;
              sp_start_r <= eff_size(csize_r[spill_r]);
            end
          end else begin
            stat_r <= ST_EXHAUSTED;
            res_r <= '0;
          end
          if (state_nxt == S_DONE) out_valid_r <= 1'b1;
        end
        S_POP_WAIT: begin
          head_r[c_r] <= link_q;
          out_valid_r <= 1'b1;
        end
        S_SPREAD: begin
          // one class visit per cycle
          if (sp_left_r >= {5'd0, sp_start_r}) begin
            if ({5'd0, sp_eff} <= sp_left_r) begin
              head_r[sp_i_r] <= {1'b1, sp_addr_r[ADDR_W-1:2]};
              sp_addr_r <= sp_addr_r + ADDR_W'(sp_eff);
              sp_left_r <= sp_left_r - {5'd0, sp_eff};
            end
            sp_i_r <= ({1'b0, sp_i_r} + 1'b1 == n_r) ? '0 : sp_i_r + 1'b1;
          end else begin
            spill_r <= sp_i_r;
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_addr))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("bad ready");
  a_addr0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_addr == '0)
    else $error("nonzero address on failure");

endmodule

[tb/testbench.sv]
module testbench
  import scba_pkg::*;
();

  typedef struct {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
  } alloc_result_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } live_block_t;

  // Allocator predictor with the store of expected results
  class alloc_scoreboard;
    int unsigned class_bytes[8];
    logic [14:0] head[8];
    logic [14:0] link[16384];
    int unsigned region_ptr, region_left, spill, pages;
    alloc_result_t expected_q[$];
    live_block_t live_q[$];
    int errors;

    function new();
      foreach (class_bytes[i]) class_bytes[i] = 0;
      foreach (head[i]) head[i] = '0;
      region_ptr = 0;
      region_left = 0;
      spill = 0;
      pages = 0;
      errors = 0;
    endfunction

    function int unsigned eff(int c);
      int unsigned v;
      v = class_bytes[c];
      if (v > 4096) v = 4096;
      return (v + 3) & ~32'd3;
    endfunction

    function int active();
      int k;
      k = 0;
      while (k < 8 && eff(k) != 0) k++;
      return k;
    endfunction

    function void push(int c, int unsigned addr);
      logic [13:0] w;
      w = addr[15:2];
      link[w] = head[c];
      head[c] = {1'b1, w};
    endfunction

    // Scatter a leftover round-robin over the class lists
    function void scatter(int unsigned addr, int unsigned left, int k);
      int i;
      int unsigned first, s;
      i = spill;
      if (i >= k) i = 0;
      first = eff(i);
      while (left >= first) begin
        s = eff(i);
        if (s <= left) begin
          push(i, addr);
          addr = (addr + s) & 32'hFFFF;
          left -= s;
        end
        i = (i + 1 == k) ? 0 : i + 1;
      end
      spill = i;
    endfunction

    // Predict the answer to an accepted request beat
    function void note_request(logic rtype, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] baddr);
      alloc_result_t r;
      live_block_t b;
      int k, c;
      bit found;
      int unsigned s, page, rest, sp_addr, sp_left;
      k = active();
      found = 0;
      c = 0;
      r.status = ST_OK;
      r.addr = '0;
      while (c < k && !found) begin
        if (eff(c) >= size) found = 1;
        else c++;
      end
      if (!found) begin
        r.status = ST_OVERSIZE;
      end else if (rtype == REQ_FREE) begin
        push(c, baddr);
      end else if (head[c][14]) begin
        r.addr = {head[c][13:0], 2'b00};
        head[c] = link[head[c][13:0]];
      end else begin
        s = eff(c);
        if (region_left >= s) begin
          r.addr = ADDR_W'(region_ptr);
          region_ptr = (region_ptr + s) & 32'hFFFF;
          region_left -= s;
        end else if (pages < 16 && s <= 4096) begin
          page = (pages * 4096) & 32'hFFFF;
          rest = 4096 - s;
          pages++;
          r.addr = ADDR_W'(page);
          if (region_left < rest) begin
            sp_addr = region_ptr;
            sp_left = region_left;
            region_ptr = (page + s) & 32'hFFFF;
            region_left = rest;
          end else begin
            sp_addr = (page + s) & 32'hFFFF;
            sp_left = rest;
          end
          scatter(sp_addr, sp_left, k);
        end else begin
          r.status = ST_EXHAUSTED;
        end
      end
      if (rtype == REQ_ALLOC && r.status == ST_OK) begin
        b.addr = r.addr;
        b.size = size;
        live_q.push_back(b);
      end
      expected_q.push_back(r);
    endfunction

    // Compare a result beat with the oldest expectation
    function void check_result(logic [1:0] status, logic [ADDR_W-1:0] addr);
      alloc_result_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat status %0d addr %h", $time, status, addr);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (status !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, status);
        errors++;
      end
      if (addr !== r.addr) begin
        $display("%0t: result_addr expected %h actual %h", $time, r.addr, addr);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_req_type;
  logic [SIZE_W-1:0] in_req_size;
  logic [ADDR_W-1:0] in_block_addr;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_status;
  logic [ADDR_W-1:0] out_result_addr;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [SIZE_W-1:0] cfg_data;

  alloc_scoreboard sb;
  bit quiet;

  size_class_block_allocator_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Collect result beats and stall the result side at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_status, out_result_addr);
    out_ready <= quiet || ($urandom_range(99) >= 9);
  end

  // Send one request beat, idling first at random
  task automatic send_req(logic rtype, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
    int gap;
    gap = (!quiet && $urandom_range(99) < 9) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rtype;
    in_req_size <= size;
    in_block_addr <= addr;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rtype, size, addr);
  endtask

  // Drain outstanding results so the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_classes(int unsigned v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= v[i][SIZE_W-1:0];
      sb.class_bytes[i] = v[i] & 32'h1FFF;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed alloc/free traffic, some noise
  task automatic random_traffic(int count);
    int k, c, pick, idx;
    int unsigned lo;
    live_block_t b;
    for (int j = 0; j < count; j++) begin
      k = sb.active();
      pick = $urandom_range(99);
      if (pick < 40 && sb.live_q.size() > 0) begin
        idx = $urandom_range(sb.live_q.size() - 1);
        b = sb.live_q[idx];
        sb.live_q.delete(idx);
        send_req(REQ_FREE, b.size,
                 b.addr | ADDR_W'($urandom_range(9) == 0 ? $urandom_range(3) : 0));
      end else if (pick < 48) begin
        send_req(REQ_FREE, SIZE_W'($urandom_range(8191)), ADDR_W'($urandom_range(16'hFFFF)));
      end else if (pick < 56 || k == 0) begin
        send_req(1'($urandom_range(1)), SIZE_W'($urandom_range(8191)),
                 ADDR_W'($urandom_range(16'hFFFF)));
      end else begin
        c = $urandom_range(k - 1);
        lo = (c > 0 && sb.eff(c - 1) < sb.eff(c)) ? sb.eff(c - 1) + 1 : 0;
        send_req(REQ_ALLOC, SIZE_W'($urandom_range(sb.eff(c), lo)),
                 ADDR_W'($urandom_range(16'hFFFF)));
      end
    end
  endtask

  initial begin
    int unsigned cfg_none[8] = '{0, 0, 0, 0, 0, 0, 0, 0};
    int unsigned cfg_full[8] = '{4, 8, 12, 24, 100, 1000, 4095, 8191};
    int unsigned cfg_short[8] = '{1, 2, 13, 0, 64, 128, 256, 512};
    int unsigned cfg_mixed[8] = '{200, 64, 64, 16, 3000, 0, 8, 8};
    int unsigned cfg_big[8] = '{4096, 4096, 5000, 4096, 4096, 4096, 4096, 4096};
    live_block_t b;
    sb = new();
    quiet = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_ALLOC;
    in_req_size = '0;
    in_block_addr = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No active class: everything is oversize
    set_classes(cfg_none);
    send_req(REQ_ALLOC, 0, 0);
    send_req(REQ_FREE, 8191, 16'hFFFF);
    drain();

    // Directed: field extremes, pops, carves, unaligned and wild frees
    set_classes(cfg_full);
    send_req(REQ_ALLOC, 0, 16'hFFFF);
    send_req(REQ_ALLOC, 1, 0);
    send_req(REQ_ALLOC, 4096, 0);
    send_req(REQ_ALLOC, 8191, 0);
    send_req(REQ_ALLOC, 4097, 0);
    send_req(REQ_ALLOC, 100, 0);
    send_req(REQ_ALLOC, 1000, 0);
    b = sb.live_q[1];
    send_req(REQ_FREE, 1, b.addr | 16'd3);
    send_req(REQ_ALLOC, 1, 0);
    send_req(REQ_FREE, 8, 16'hFFFF);
    send_req(REQ_ALLOC, 8, 0);
    send_req(REQ_FREE, 8191, 16'h1234);
    send_req(REQ_ALLOC, 12, 0);
    send_req(REQ_ALLOC, 24, 0);
    send_req(REQ_ALLOC, 4095, 0);
    send_req(REQ_FREE, 4096, 16'h0000);
    send_req(REQ_ALLOC, 4096, 0);
    drain();
    random_traffic(350);
    drain();

    // Gap in the class list and a stale round-robin start
    set_classes(cfg_short);
    random_traffic(250);
    drain();

    // Repeated, non-ascending sizes with no idling on either side
    set_classes(cfg_mixed);
    quiet = 1;
    random_traffic(250);
    drain();
    quiet = 0;

    // Page-sized classes run the arena dry
    set_classes(cfg_big);
    random_traffic(200);
    drain();

    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[filelist.f]
rtl/scba_pkg.sv
rtl/size_class_block_allocator_unit.sv
tb/testbench.sv
